FILE: rtl/core/naps_pkg.sv
package naps_pkg;

    localparam int NUM_TUBES     = 6;
    localparam int FIELD_NIBBLES = 6;
    localparam int DIGIT_W       = 4;
    localparam int FIELD_W       = FIELD_NIBBLES * DIGIT_W;
    localparam int SETTLED_W     = $clog2(NUM_TUBES + 1);
    localparam int ELAPSED_W     = 17;
    localparam int INTERVAL_W    = 16;
    localparam int SPT_W         = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [DIGIT_W-1:0]   DIGIT_MAX   = 4'd9;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_INTERVAL  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANIM_KIND      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEPS_PER_TUBE = 2'd2;

    typedef enum logic [1:0] {
        ANIM_HOLD   = 2'd0,
        ANIM_UP     = 2'd1,
        ANIM_DOWN   = 2'd2,
        ANIM_RANDOM = 2'd3
    } anim_kind_t;

    localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 16'd100;
    localparam anim_kind_t            RESET_KIND     = ANIM_UP;
    localparam logic [SPT_W-1:0]      RESET_SPT      = 8'd10;

    typedef struct packed {
        logic                 step;
        logic                 finish;
        anim_kind_t           kind;
        logic [SETTLED_W-1:0] settled;
    } naps_ctl_t;

    typedef struct packed {
        logic [FIELD_W-1:0] shown;
        logic               stepped;
        logic               finished;
    } naps_result_t;

endpackage

FILE: rtl/core/naps_lane.sv
module naps_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  naps_pkg::naps_ctl_t            ctl,
    input  logic                           is_settled,
    input  logic                           copy_target,
    input  logic [naps_pkg::DIGIT_W-1:0]   target,
    input  logic [naps_pkg::DIGIT_W-1:0]   rnd,
    output logic [naps_pkg::DIGIT_W-1:0]   digit_next
);

    logic [naps_pkg::DIGIT_W-1:0] digit_reg;
    logic [naps_pkg::DIGIT_W-1:0] stepped_digit;

    always_comb
    begin
        stepped_digit = digit_reg;
        if (is_settled)
        begin
            if (copy_target)
            begin
                stepped_digit = target;
            end
        end
        else
        begin
            unique case (ctl.kind)
                naps_pkg::ANIM_HOLD:
                begin
                    stepped_digit = digit_reg;
                end
                naps_pkg::ANIM_UP:
                begin
                    stepped_digit = (digit_reg >= naps_pkg::DIGIT_MAX) ? '0
                                    : digit_reg + 1'b1;
                end
                naps_pkg::ANIM_DOWN:
                begin
                    stepped_digit = (digit_reg == '0) ? naps_pkg::DIGIT_MAX
                                    : digit_reg - 1'b1;
                end
                naps_pkg::ANIM_RANDOM:
                begin
                    stepped_digit = (rnd > naps_pkg::DIGIT_MAX) ? naps_pkg::DIGIT_MAX
                                    : rnd;
                end
                default:
                begin
                    stepped_digit = digit_reg;
                end
            endcase
        end
    end

    assign digit_next = ctl.step ? stepped_digit : digit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else if (advance)
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

FILE: rtl/core/naps_ctrl.sv
module naps_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [naps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [naps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              advance,
    output naps_pkg::naps_ctl_t               ctl
);

    logic [naps_pkg::INTERVAL_W-1:0] interval_reg;
    naps_pkg::anim_kind_t            kind_reg;
    logic [naps_pkg::SPT_W-1:0]      spt_reg;

    logic [naps_pkg::ELAPSED_W-1:0]  elapsed_reg;
    logic [naps_pkg::ELAPSED_W-1:0]  elapsed_next;
    logic [naps_pkg::ELAPSED_W-1:0]  elapsed_inc;
    logic [naps_pkg::SPT_W-1:0]      count_reg;
    logic [naps_pkg::SPT_W-1:0]      count_next;
    logic [naps_pkg::SETTLED_W-1:0]  settled_reg;
    logic [naps_pkg::SETTLED_W-1:0]  settled_next;
    logic                            step;
    logic                            finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= naps_pkg::RESET_INTERVAL;
            kind_reg     <= naps_pkg::RESET_KIND;
            spt_reg      <= naps_pkg::RESET_SPT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                naps_pkg::CFG_STEP_INTERVAL:
                begin
                    interval_reg <= cfg_data[naps_pkg::INTERVAL_W-1:0];
                end
                naps_pkg::CFG_ANIM_KIND:
                begin
                    kind_reg <= naps_pkg::anim_kind_t'(cfg_data[1:0]);
                end
                naps_pkg::CFG_STEPS_PER_TUBE:
                begin
                    spt_reg <= cfg_data[naps_pkg::SPT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        elapsed_inc  = (elapsed_reg == naps_pkg::ELAPSED_MAX) ? elapsed_reg
                       : elapsed_reg + 1'b1;
        step         = elapsed_inc > {1'b0, interval_reg};
        elapsed_next = step ? '0 : elapsed_inc;
        count_next   = count_reg;
        settled_next = settled_reg;
        finish       = 1'b0;
        if (step)
        begin
            priority if (count_reg < spt_reg)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (settled_reg < naps_pkg::SETTLED_W'(naps_pkg::NUM_TUBES))
            begin
                count_next   = '0;
                settled_next = settled_reg + 1'b1;
            end
            else
            begin
                count_next   = '0;
                settled_next = '0;
                finish       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            count_reg   <= '0;
            settled_reg <= '0;
        end
        else if (advance)
        begin
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            settled_reg <= settled_next;
        end
    end

    assign ctl.step    = step;
    assign ctl.finish  = finish;
    assign ctl.kind    = kind_reg;
    assign ctl.settled = settled_reg;

endmodule

FILE: rtl/core/nixie_anti_poisoning_sequencer_core.sv
// Each result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one tick per cycle while in_stall is low; all tube lanes update in parallel on each accepted tick.
// A two-entry output buffer keeps input accepted while one result waits.
// Reset (rst_n, asynchronous, active low) zeroes the tube digits and counters,
// loads the register defaults and empties the output buffer.
module nixie_anti_poisoning_sequencer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [naps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [naps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [naps_pkg::FIELD_W-1:0]      target_digits,
    input  logic [naps_pkg::FIELD_W-1:0]      random_digits,
    input  logic                              copy_target,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [naps_pkg::FIELD_W-1:0]      shown_digits,
    output logic                              stepped,
    output logic                              finished
);

    naps_pkg::naps_ctl_t    ctl;
    naps_pkg::naps_result_t result;
    naps_pkg::naps_result_t out_reg;
    naps_pkg::naps_result_t skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    logic                   in_fire;
    logic                   out_fire;

    logic [naps_pkg::DIGIT_W-1:0] digit_next [naps_pkg::NUM_TUBES];
    logic [naps_pkg::FIELD_W-1:0] shown_next;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    naps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_fire),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < naps_pkg::NUM_TUBES; i++)
    begin : g_lane
        logic [naps_pkg::DIGIT_W-1:0] lane_target;
        logic [naps_pkg::DIGIT_W-1:0] lane_rnd;

        if (i < naps_pkg::FIELD_NIBBLES)
        begin : g_field
            assign lane_target = target_digits[i*naps_pkg::DIGIT_W +: naps_pkg::DIGIT_W];
            assign lane_rnd    = random_digits[i*naps_pkg::DIGIT_W +: naps_pkg::DIGIT_W];
        end
        else
        begin : g_nofield
            assign lane_target = '0;
            assign lane_rnd    = '0;
        end

        naps_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (in_fire),
            .ctl         (ctl),
            .is_settled  (naps_pkg::SETTLED_W'(i) < ctl.settled),
            .copy_target (copy_target),
            .target      (lane_target),
            .rnd         (lane_rnd),
            .digit_next  (digit_next[i])
        );
    end

    for (genvar j = 0; j < naps_pkg::FIELD_NIBBLES; j++)
    begin : g_pack
        if (j < naps_pkg::NUM_TUBES)
        begin : g_tube
            assign shown_next[j*naps_pkg::DIGIT_W +: naps_pkg::DIGIT_W] = digit_next[j];
        end
        else
        begin : g_blank
            assign shown_next[j*naps_pkg::DIGIT_W +: naps_pkg::DIGIT_W] = '0;
        end
    end

    assign result.shown    = shown_next;
    assign result.stepped  = ctl.step;
    assign result.finished = ctl.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= result;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign shown_digits = out_reg.shown;
    assign stepped      = out_reg.stepped;
    assign finished     = out_reg.finished;

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held while the output register is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ctl.finish) |=> (ctl.settled == '0))
        else $error("Settle index not cleared after the sequence finished.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(ctl.settled))
        else $error("Settle index moved without an input transaction.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.finished) |-> out_reg.stepped)
        else $error("Finished flag raised on a result without a step.");

endmodule

FILE: sim/tb_nixie_anti_poisoning_sequencer_core.sv
module tb_nixie_anti_poisoning_sequencer_core;
    import naps_pkg::*;

    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 230;
    localparam int DRAIN_CYCLES     = 8;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        bit                     is_reg;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [FIELD_W-1:0]     target;
        logic [FIELD_W-1:0]     rnd;
        logic                   copy;
        bit                     typed;
        naps_result_t           want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [FIELD_W-1:0]     target_digits = '0;
    logic [FIELD_W-1:0]     random_digits = '0;
    logic                   copy_target = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [FIELD_W-1:0]     shown_digits;
    logic                   stepped;
    logic                   finished;

    bit                     typed_valid = 1'b0;
    naps_result_t           typed_result = '0;

    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     error_count = 0;

    naps_result_t           pending_displays[$];
    stim_row_t              directed_rows[$];

    logic [DIGIT_W-1:0]     tube_now [NUM_TUBES];
    logic [SPT_W-1:0]       step_count_now;
    logic [SETTLED_W-1:0]   settled_now;
    logic [ELAPSED_W-1:0]   elapsed_now;
    logic [INTERVAL_W-1:0]  interval_now;
    anim_kind_t             kind_now;
    logic [SPT_W-1:0]       spt_now;

    nixie_anti_poisoning_sequencer_core dut (.*);

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    task automatic advance_tick(input logic [FIELD_W-1:0] target, input logic [FIELD_W-1:0] rnd,
                                input logic copy, output naps_result_t res);
        logic [DIGIT_W-1:0] d;
        logic [DIGIT_W-1:0] r;
        res = '0;
        if (elapsed_now != ELAPSED_MAX)
            elapsed_now = elapsed_now + 1'b1;
        if (elapsed_now > {1'b0, interval_now})
        begin
            elapsed_now = '0;
            res.stepped = 1'b1;
            for (int i = 0; i < NUM_TUBES; i++)
            begin
                d = tube_now[i];
                r = rnd[i*DIGIT_W +: DIGIT_W];
                if (i < settled_now)
                begin
                    if (copy)
                        d = target[i*DIGIT_W +: DIGIT_W];
                end
                else
                begin
                    case (kind_now)
                        ANIM_UP:     d = (d >= DIGIT_MAX) ? '0 : d + 1'b1;
                        ANIM_DOWN:   d = (d == '0) ? DIGIT_MAX : d - 1'b1;
                        ANIM_RANDOM: d = (r > DIGIT_MAX) ? DIGIT_MAX : r;
                        default:     ;
                    endcase
                end
                tube_now[i] = d;
            end
            if (step_count_now < spt_now)
                step_count_now = step_count_now + 1'b1;
            else if (settled_now < NUM_TUBES)
            begin
                settled_now = settled_now + 1'b1;
                step_count_now = '0;
            end
            else
            begin
                step_count_now = '0;
                settled_now = '0;
                res.finished = 1'b1;
            end
        end
        for (int i = 0; i < NUM_TUBES; i++)
            res.shown[i*DIGIT_W +: DIGIT_W] = tube_now[i];
    endtask

    task automatic flag_error(input string what, input naps_result_t want);
        if (error_count < REPORT_LIMIT)
            $display("%s: shown %06h exp %06h, stepped %b exp %b, finished %b exp %b",
                     what, shown_digits, want.shown, stepped, want.stepped,
                     finished, want.finished);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        naps_result_t predicted;
        if (rst_n && in_valid && !in_stall)
        begin
            advance_tick(target_digits, random_digits, copy_target, predicted);
            pending_displays.push_back(typed_valid ? typed_result : predicted);
        end
    end

    always @(posedge clk)
    begin
        naps_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_displays.size() == 0)
                flag_error("unexpected transaction", '0);
            else
            begin
                want = pending_displays.pop_front();
                if (shown_digits !== want.shown || stepped !== want.stepped
                    || finished !== want.finished)
                    flag_error("mismatch", want);
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_displays.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STEP_INTERVAL:  interval_now = value;
            CFG_ANIM_KIND:      kind_now = anim_kind_t'(value[1:0]);
            CFG_STEPS_PER_TUBE: spt_now = value[SPT_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic send_tick(input logic [FIELD_W-1:0] target, input logic [FIELD_W-1:0] rnd,
                             input logic copy, input bit typed, input naps_result_t want);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        target_digits <= target;
        random_digits <= rnd;
        copy_target <= copy;
        typed_valid <= typed;
        typed_result <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic stim_row_t tick_row(input logic [FIELD_W-1:0] target,
                                           input logic [FIELD_W-1:0] rnd, input logic copy,
                                           input bit typed, input naps_result_t want);
        stim_row_t row;
        row = '{is_reg: 1'b0, reg_index: '0, reg_value: '0, target: target, rnd: rnd,
                copy: copy, typed: typed, want: want};
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row = '{is_reg: 1'b1, reg_index: idx, reg_value: value, target: '0, rnd: '0,
                copy: 1'b0, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic logic [FIELD_W-1:0] digit_word();
        logic [FIELD_W-1:0] w;
        for (int i = 0; i < FIELD_NIBBLES; i++)
            w[i*DIGIT_W +: DIGIT_W] = ($urandom_range(0, 7) == 0)
                                      ? DIGIT_W'($urandom_range(0, 15))
                                      : DIGIT_W'($urandom_range(0, 9));
        return w;
    endfunction

    initial
    begin
        naps_result_t none;
        logic [FIELD_W-1:0] rnd;
        none = '0;
        for (int i = 0; i < NUM_TUBES; i++)
            tube_now[i] = '0;
        step_count_now = '0;
        settled_now = '0;
        elapsed_now = '0;
        interval_now = RESET_INTERVAL;
        kind_now = RESET_KIND;
        spt_now = RESET_SPT;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rows.push_back(tick_row(24'h000000, 24'h000000, 1'b0, 1'b1, '{24'h0, 1'b0, 1'b0}));
        directed_rows.push_back(tick_row(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, '{24'h0, 1'b0, 1'b0}));
        directed_rows.push_back(reg_row(CFG_STEP_INTERVAL, 16'hFFFF));
        directed_rows.push_back(tick_row(24'h123456, 24'h000000, 1'b1, 1'b1, '{24'h0, 1'b0, 1'b0}));
        directed_rows.push_back(reg_row(CFG_STEP_INTERVAL, 16'd0));
        directed_rows.push_back(reg_row(CFG_STEPS_PER_TUBE, 16'd0));
        directed_rows.push_back(reg_row(CFG_ANIM_KIND, {14'd0, ANIM_UP}));
        directed_rows.push_back(tick_row(24'h000000, 24'h000000, 1'b1, 1'b1,
                                         '{24'h111111, 1'b1, 1'b0}));
        directed_rows.push_back(tick_row(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, none));
        directed_rows.push_back(tick_row(24'h987654, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(tick_row(24'h000000, 24'hFFFFFF, 1'b0, 1'b0, none));
        directed_rows.push_back(tick_row(24'h999999, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(tick_row(24'hFFFFFF, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(tick_row(24'hFFFFFF, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(tick_row(24'h000000, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(reg_row(CFG_ANIM_KIND, {14'd0, ANIM_DOWN}));
        directed_rows.push_back(tick_row(24'h000000, 24'h000000, 1'b0, 1'b0, none));
        directed_rows.push_back(tick_row(24'hFFFFFF, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(reg_row(CFG_ANIM_KIND, {14'd0, ANIM_RANDOM}));
        directed_rows.push_back(tick_row(24'h000000, 24'hFFFFFF, 1'b1, 1'b0, none));
        directed_rows.push_back(tick_row(24'h000000, 24'h5A3F90, 1'b1, 1'b0, none));
        directed_rows.push_back(reg_row(CFG_ANIM_KIND, {14'd0, ANIM_HOLD}));
        directed_rows.push_back(tick_row(24'h123456, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(tick_row(24'h654321, 24'h000000, 1'b0, 1'b0, none));
        directed_rows.push_back(reg_row(CFG_STEPS_PER_TUBE, 16'd255));
        directed_rows.push_back(tick_row(24'h246802, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(reg_row(CFG_STEP_INTERVAL, 16'd2));
        directed_rows.push_back(tick_row(24'h135791, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(tick_row(24'h135791, 24'h000000, 1'b1, 1'b0, none));
        directed_rows.push_back(tick_row(24'h135791, 24'h000000, 1'b1, 1'b0, none));

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].is_reg)
                write_reg(directed_rows[k].reg_index, directed_rows[k].reg_value);
            else
                send_tick(directed_rows[k].target, directed_rows[k].rnd, directed_rows[k].copy,
                          directed_rows[k].typed, directed_rows[k].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 22;
                    recv_stall_pct = 22;
                end
            endcase
            write_reg(CFG_STEP_INTERVAL, (p == 5) ? 16'($urandom_range(20, 60))
                                                  : 16'($urandom_range(0, 3)));
            write_reg(CFG_ANIM_KIND, 16'($urandom_range(0, 3)));
            write_reg(CFG_STEPS_PER_TUBE, (p == 6) ? 16'd255 : 16'($urandom_range(0, 4)));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                rnd = $urandom_range(0, 1) ? digit_word() : FIELD_W'($urandom);
                send_tick(digit_word(), rnd, $urandom_range(0, 9) != 0, 1'b0, none);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_displays.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_displays.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
